>>> rtl/sarc_pkg.sv
// scan/avoid robot controller: shared types, codes and reset values
// used by the step logic, the top level and the port checker
`default_nettype none

package sarc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SCAN    = 3'd1,
    MODE_DECIDE  = 3'd2,
    MODE_MOVE    = 3'd3,
    MODE_ALERT   = 3'd4,
    MODE_REVERSE = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    MOT_NONE  = 3'd0,
    MOT_STOP  = 3'd1,
    MOT_FWD   = 3'd2,
    MOT_BACK  = 3'd3,
    MOT_LEFT  = 3'd4,
    MOT_RIGHT = 3'd5
  } motor_e;

  typedef enum logic [1:0] {
    BZ_NONE   = 2'd0,
    BZ_STOP   = 2'd1,
    BZ_MELODY = 2'd2,
    BZ_ALERT  = 2'd3
  } buzz_e;

  typedef enum logic [2:0] {
    REG_SAFE_DIST   = 3'd0,
    REG_SCAN_PERIOD = 3'd1,
    REG_AVOID_TIME  = 3'd2,
    REG_SCAN_LOW    = 3'd3,
    REG_SCAN_HIGH   = 3'd4,
    REG_SCAN_STEP   = 3'd5
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  localparam logic [9:0] FarCm     = 10'd999;
  localparam logic [7:0] CenterDeg = 8'd90;

  localparam logic [9:0]  SafeDistRst   = 10'd20;
  localparam logic [9:0]  ScanPeriodRst = 10'd40;
  localparam logic [13:0] AvoidTimeRst  = 14'd120;
  localparam logic [7:0]  ScanLowRst    = 8'd30;
  localparam logic [7:0]  ScanHighRst   = 8'd150;
  localparam logic [6:0]  ScanStepRst   = 7'd10;

  typedef struct packed {
    logic [9:0]  safe_dist;
    logic [9:0]  scan_period;
    logic [13:0] avoid_time;
    logic [7:0]  scan_low;
    logic [7:0]  scan_high;
    logic [6:0]  scan_step;
  } cfg_t;

  typedef struct packed {
    mode_e       mode;
    mode_e       prior;
    logic        auto_on;
    logic        manual_on;
    logic [7:0]  sweep_angle;
    logic        sweep_down;
    logic [31:0] last_step;
    logic [9:0]  min_cm;
    logic [7:0]  min_deg;
    logic        turning;
    logic [31:0] turn_start;
  } state_t;

  typedef struct packed {
    mode_e      mode;
    motor_e     motor;
    logic       servo_write;
    logic [7:0] servo_angle;
    buzz_e      buzz;
    logic       auto_on;
    logic       manual_on;
    logic [9:0] nearest_cm;
    logic [7:0] nearest_deg;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/sarc_step.sv
// scan/avoid robot controller: next-state and result logic for one word
// depends on sarc_pkg
`default_nettype none

module sarc_step
  import sarc_pkg::*;
(
  input  cfg_t        cfg_i,
  input  state_t      state_i,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] now_ms_i,
  input  logic [9:0]  distance_cm_i,
  output state_t      state_o,
  output result_t     result_o
);

  localparam logic [7:0] ChTLo = 8'h74;
  localparam logic [7:0] ChTUp = 8'h54;
  localparam logic [7:0] ChXLo = 8'h78;
  localparam logic [7:0] ChXUp = 8'h58;
  localparam logic [7:0] ChWLo = 8'h77;
  localparam logic [7:0] ChWUp = 8'h57;
  localparam logic [7:0] ChSLo = 8'h73;
  localparam logic [7:0] ChSUp = 8'h53;
  localparam logic [7:0] ChALo = 8'h61;
  localparam logic [7:0] ChAUp = 8'h41;
  localparam logic [7:0] ChDLo = 8'h64;
  localparam logic [7:0] ChDUp = 8'h44;
  localparam logic [7:0] ChRLo = 8'h72;
  localparam logic [7:0] ChRUp = 8'h52;

  logic [31:0]       step_elapsed;
  logic [31:0]       turn_elapsed;
  logic              step_due;
  logic              turn_done;
  logic              new_min;
  logic signed [9:0] sweep_next;
  logic signed [9:0] high_s;
  logic signed [9:0] low_s;
  motor_e            motor;
  logic              swr;
  logic [7:0]        sang;
  buzz_e             buzz;
  state_t            nxt;

  assign step_elapsed = now_ms_i - state_i.last_step;
  assign turn_elapsed = now_ms_i - state_i.turn_start;
  assign step_due     = step_elapsed >= {22'd0, cfg_i.scan_period};
  assign turn_done    = turn_elapsed > {18'd0, cfg_i.avoid_time};
  assign new_min      = (distance_cm_i != 10'd0) && (distance_cm_i < state_i.min_cm);
  assign high_s       = $signed({2'b00, cfg_i.scan_high});
  assign low_s        = $signed({2'b00, cfg_i.scan_low});
  // no wrap: the step may run past either end before clamping
  assign sweep_next   = state_i.sweep_down
                      ? $signed({2'b00, state_i.sweep_angle}) - $signed({3'b000, cfg_i.scan_step})
                      : $signed({2'b00, state_i.sweep_angle}) + $signed({3'b000, cfg_i.scan_step});

  always_comb begin
    nxt   = state_i;
    motor = MOT_NONE;
    swr   = 1'b0;
    sang  = 8'd0;
    buzz  = BZ_NONE;
    if (cmd_i) begin
      case (rx_byte_i) inside
        ChTLo, ChTUp: begin
          nxt.auto_on   = 1'b1;
          nxt.manual_on = 1'b0;
          buzz          = BZ_STOP;
          nxt.mode      = MODE_SCAN;
        end
        ChXLo, ChXUp: begin
          nxt.auto_on   = 1'b0;
          nxt.manual_on = 1'b0;
          motor         = MOT_STOP;
          buzz          = BZ_STOP;
          nxt.mode      = MODE_IDLE;
        end
        ChWLo, ChWUp: begin
          nxt.manual_on = 1'b1;
          nxt.auto_on   = 1'b0;
          buzz          = BZ_STOP;
          motor         = MOT_FWD;
          nxt.mode      = MODE_MOVE;
        end
        ChSLo, ChSUp: begin
          nxt.manual_on = 1'b1;
          nxt.auto_on   = 1'b0;
          motor         = MOT_BACK;
          nxt.mode      = MODE_REVERSE;
        end
        ChALo, ChAUp: begin
          nxt.manual_on = 1'b1;
          nxt.auto_on   = 1'b0;
          buzz          = BZ_STOP;
          motor         = MOT_LEFT;
        end
        ChDLo, ChDUp: begin
          nxt.manual_on = 1'b1;
          nxt.auto_on   = 1'b0;
          buzz          = BZ_STOP;
          motor         = MOT_RIGHT;
        end
        ChRLo, ChRUp: begin
          swr  = 1'b1;
          sang = CenterDeg;
        end
        default: begin
        end
      endcase
    end else begin
      // mode change since the previous tick
      if (state_i.mode != state_i.prior) begin
        if (state_i.mode == MODE_REVERSE) begin
          buzz = BZ_MELODY;
        end else if (state_i.mode == MODE_ALERT) begin
          buzz = BZ_ALERT;
        end
        nxt.prior = state_i.mode;
      end
      if (state_i.auto_on) begin
        case (state_i.mode)
          MODE_SCAN: begin
            if (step_due) begin
              nxt.last_step = now_ms_i;
              swr           = 1'b1;
              sang          = state_i.sweep_angle;
              if (new_min) begin
                nxt.min_cm  = distance_cm_i;
                nxt.min_deg = state_i.sweep_angle;
              end
              if (sweep_next >= high_s) begin
                nxt.sweep_angle = cfg_i.scan_high;
                nxt.sweep_down  = 1'b1;
                nxt.mode        = MODE_DECIDE;
              end else if (sweep_next <= low_s) begin
                nxt.sweep_angle = cfg_i.scan_low;
                nxt.sweep_down  = 1'b0;
                nxt.mode        = MODE_DECIDE;
              end else begin
                nxt.sweep_angle = sweep_next[7:0];
              end
            end
          end
          MODE_DECIDE: begin
            nxt.mode = (state_i.min_cm > cfg_i.safe_dist) ? MODE_MOVE : MODE_ALERT;
          end
          MODE_MOVE: begin
            motor    = MOT_FWD;
            nxt.mode = MODE_SCAN;
          end
          MODE_REVERSE: begin
            motor = MOT_BACK;
          end
          MODE_ALERT: begin
            if (!state_i.turning) begin
              motor          = (state_i.min_deg < CenterDeg) ? MOT_RIGHT : MOT_LEFT;
              nxt.turn_start = now_ms_i;
              nxt.turning    = 1'b1;
            end else if (turn_done) begin
              motor       = MOT_STOP;
              nxt.turning = 1'b0;
              nxt.min_cm  = FarCm;
              nxt.mode    = MODE_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign state_o = nxt;

  always_comb begin
    result_o.mode        = nxt.mode;
    result_o.motor       = motor;
    result_o.servo_write = swr;
    result_o.servo_angle = sang;
    result_o.buzz        = buzz;
    result_o.auto_on     = nxt.auto_on;
    result_o.manual_on   = nxt.manual_on;
    result_o.nearest_cm  = nxt.min_cm;
    result_o.nearest_deg = nxt.min_deg;
  end

endmodule

`default_nettype wire

>>> rtl/scan_avoid_robot_controller.sv
// Obstacle-avoidance robot controller, one result word per input word.
// Each accepted input word (a loop tick or a received command byte) is
// evaluated in the cycle it is accepted: the controller state registers are
// updated at that edge and the result word is written into a two-entry output
// buffer, so a word can be accepted in every cycle while the buffer has room;
// results leave the buffer in order. in_ready_o drops only when both output
// entries hold words that the consumer has not yet taken; the buffer
// depth sets that limit. The configuration port is always ready and should
// only be written while no word is in flight. Indexes 6 and 7 are ignored.
// depends on sarc_pkg and sarc_step
`default_nettype none

module scan_avoid_robot_controller
  import sarc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // input words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [31:0]         now_ms_i,
  input  logic [9:0]          distance_cm_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          robot_mode_o,
  output logic [2:0]          motor_action_o,
  output logic                servo_write_o,
  output logic [7:0]          servo_angle_o,
  output logic [1:0]          buzzer_action_o,
  output logic                auto_enabled_o,
  output logic                manual_enabled_o,
  output logic [9:0]          nearest_cm_o,
  output logic [7:0]          nearest_deg_o
);

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  result_t result_d;
  result_t res_q [2];
  logic    wr_ptr_q;
  logic    rd_ptr_q;
  logic [1:0] count_q;
  logic    in_fire;
  logic    out_fire;
  result_t head;

  // config register file
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.safe_dist   <= SafeDistRst;
      cfg_q.scan_period <= ScanPeriodRst;
      cfg_q.avoid_time  <= AvoidTimeRst;
      cfg_q.scan_low    <= ScanLowRst;
      cfg_q.scan_high   <= ScanHighRst;
      cfg_q.scan_step   <= ScanStepRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SAFE_DIST:   cfg_q.safe_dist   <= cfg_wdata_i[9:0];
        REG_SCAN_PERIOD: cfg_q.scan_period <= cfg_wdata_i[9:0];
        REG_AVOID_TIME:  cfg_q.avoid_time  <= cfg_wdata_i[13:0];
        REG_SCAN_LOW:    cfg_q.scan_low    <= cfg_wdata_i[7:0];
        REG_SCAN_HIGH:   cfg_q.scan_high   <= cfg_wdata_i[7:0];
        REG_SCAN_STEP:   cfg_q.scan_step   <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // per-word decision logic
  sarc_step u_step (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .cmd_i         (cmd_i),
    .rx_byte_i     (rx_byte_i),
    .now_ms_i      (now_ms_i),
    .distance_cm_i (distance_cm_i),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  // controller state advances only on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode        <= MODE_IDLE;
      state_q.prior       <= MODE_IDLE;
      state_q.auto_on     <= 1'b0;
      state_q.manual_on   <= 1'b0;
      state_q.sweep_angle <= ScanLowRst;
      state_q.sweep_down  <= 1'b0;
      state_q.last_step   <= 32'd0;
      state_q.min_cm      <= FarCm;
      state_q.min_deg     <= CenterDeg;
      state_q.turning     <= 1'b0;
      state_q.turn_start  <= 32'd0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // two-entry output buffer keeps the input side moving while a result waits
  assign in_ready_o  = (count_q != 2'd2);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != 2'd0);
  assign out_fire    = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q[wr_ptr_q] <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (out_fire) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({in_fire, out_fire})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign head = res_q[rd_ptr_q];

  assign robot_mode_o     = head.mode;
  assign motor_action_o   = head.motor;
  assign servo_write_o    = head.servo_write;
  assign servo_angle_o    = head.servo_angle;
  assign buzzer_action_o  = head.buzz;
  assign auto_enabled_o   = head.auto_on;
  assign manual_enabled_o = head.manual_on;
  assign nearest_cm_o     = head.nearest_cm;
  assign nearest_deg_o    = head.nearest_deg;

endmodule

`default_nettype wire

>>> rtl/sarc_checker.sv
// scan/avoid robot controller: port-level checks and their bind
// depends on sarc_pkg; attaches to scan_avoid_robot_controller
`default_nettype none

module sarc_checker
  import sarc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] robot_mode_o,
  input logic [2:0] motor_action_o,
  input logic       servo_write_o,
  input logic [7:0] servo_angle_o,
  input logic [1:0] buzzer_action_o,
  input logic       auto_enabled_o,
  input logic       manual_enabled_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(robot_mode_o)
      && $stable(motor_action_o) && $stable(servo_angle_o) && $stable(buzzer_action_o))
    else $error("result word changed while stalled");

  // input only back-pressures when results are pending
  a_ready_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_angle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !servo_write_o |-> servo_angle_o == 8'd0)
    else $error("servo angle set without servo write");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(auto_enabled_o && manual_enabled_o))
    else $error("auto and manual both enabled");

  // the melody only sounds on a tick that stays in reverse
  a_melody_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && buzzer_action_o == BZ_MELODY |-> robot_mode_o == MODE_REVERSE)
    else $error("melody outside reverse mode");

endmodule

bind scan_avoid_robot_controller sarc_checker u_sarc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .robot_mode_o     (robot_mode_o),
  .motor_action_o   (motor_action_o),
  .servo_write_o    (servo_write_o),
  .servo_angle_o    (servo_angle_o),
  .buzzer_action_o  (buzzer_action_o),
  .auto_enabled_o   (auto_enabled_o),
  .manual_enabled_o (manual_enabled_o)
);

`default_nettype wire

>>> sim/scan_avoid_robot_controller_tb.sv
// self-checking testbench for the scan/avoid robot controller: a clocked
// driver and monitor around dut, with a cycle-free predictor of the controller
// depends on sarc_pkg and scan_avoid_robot_controller
module scan_avoid_robot_controller_tb;
  import sarc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one input word as it is driven onto the ports
  typedef struct packed {
    logic        cmd;
    logic [7:0]  rx;
    logic [31:0] now;
    logic [9:0]  dist_cm;
  } in_word_t;

  localparam int unsigned ResetCycles = 7;
  localparam int unsigned DrainCycles = 4;     // output buffer is two deep
  localparam int unsigned StallLimit  = 4000;  // cycles with no handshake on any channel
  localparam int unsigned PhaseWords  = 105;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CfgDataW-1:0] cfg_wdata_i      = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic                cmd_i            = 1'b0;
  logic [7:0]          rx_byte_i        = '0;
  logic [31:0]         now_ms_i         = '0;
  logic [9:0]          distance_cm_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [2:0]          robot_mode_o;
  logic [2:0]          motor_action_o;
  logic                servo_write_o;
  logic [7:0]          servo_angle_o;
  logic [1:0]          buzzer_action_o;
  logic                auto_enabled_o;
  logic                manual_enabled_o;
  logic [9:0]          nearest_cm_o;
  logic [7:0]          nearest_deg_o;

  scan_avoid_robot_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .rx_byte_i        (rx_byte_i),
    .now_ms_i         (now_ms_i),
    .distance_cm_i    (distance_cm_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .robot_mode_o     (robot_mode_o),
    .motor_action_o   (motor_action_o),
    .servo_write_o    (servo_write_o),
    .servo_angle_o    (servo_angle_o),
    .buzzer_action_o  (buzzer_action_o),
    .auto_enabled_o   (auto_enabled_o),
    .manual_enabled_o (manual_enabled_o),
    .nearest_cm_o     (nearest_cm_o),
    .nearest_deg_o    (nearest_deg_o)
  );

  always #5 clk_i = ~clk_i;

  // words waiting to be driven, and the results the predictor expects
  in_word_t    robot_inputs[$];
  result_t     expected_outputs[$];

  // predictor copy of the controller registers and its configuration
  state_t      bot;
  cfg_t        bot_cfg;

  int unsigned in_idle_pct  = 22;
  int unsigned out_idle_pct = 78;
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;
  logic [31:0] sim_now      = '0;  // running ms clock for generated ticks

  // ---------------------------------------------------------------------------
  // predictor: one input word in, one result word out, state updated in place
  // ---------------------------------------------------------------------------
  function automatic result_t robot_step(input in_word_t w);
    result_t     r;
    mode_e       cur;
    logic [31:0] elapsed;
    int          next_deg;
    r = '0;
    if (w.cmd) begin
      case (w.rx)
        "t", "T": begin
          bot.auto_on   = 1'b1;
          bot.manual_on = 1'b0;
          r.buzz        = BZ_STOP;
          bot.mode      = MODE_SCAN;
        end
        "x", "X": begin
          bot.auto_on   = 1'b0;
          bot.manual_on = 1'b0;
          r.motor       = MOT_STOP;
          r.buzz        = BZ_STOP;
          bot.mode      = MODE_IDLE;
        end
        "w", "W": begin
          bot.manual_on = 1'b1;
          bot.auto_on   = 1'b0;
          r.buzz        = BZ_STOP;
          r.motor       = MOT_FWD;
          bot.mode      = MODE_MOVE;
        end
        // reverse leaves the buzzer alone
        "s", "S": begin
          bot.manual_on = 1'b1;
          bot.auto_on   = 1'b0;
          r.motor       = MOT_BACK;
          bot.mode      = MODE_REVERSE;
        end
        // manual turns keep the current mode
        "a", "A": begin
          bot.manual_on = 1'b1;
          bot.auto_on   = 1'b0;
          r.buzz        = BZ_STOP;
          r.motor       = MOT_LEFT;
        end
        "d", "D": begin
          bot.manual_on = 1'b1;
          bot.auto_on   = 1'b0;
          r.buzz        = BZ_STOP;
          r.motor       = MOT_RIGHT;
        end
        "r", "R": begin
          r.servo_write = 1'b1;
          r.servo_angle = CenterDeg;
        end
        default: ;
      endcase
    end else begin
      // mode change since the last tick drives the buzzer
      cur = bot.mode;
      if (cur != bot.prior) begin
        if (cur == MODE_REVERSE) begin
          r.buzz = BZ_MELODY;
        end else if (cur == MODE_ALERT) begin
          r.buzz = BZ_ALERT;
        end
        bot.prior = cur;
      end
      if (bot.auto_on) begin
        case (cur)
          MODE_SCAN: begin
            elapsed = w.now - bot.last_step;
            if (elapsed >= 32'(bot_cfg.scan_period)) begin
              bot.last_step = w.now;
              r.servo_write = 1'b1;
              r.servo_angle = bot.sweep_angle;
              // no echo is never a minimum
              if (w.dist_cm != 10'd0 && w.dist_cm < bot.min_cm) begin
                bot.min_cm  = w.dist_cm;
                bot.min_deg = bot.sweep_angle;
              end
              next_deg = bot.sweep_down ?
                         int'(bot.sweep_angle) - int'(bot_cfg.scan_step) :
                         int'(bot.sweep_angle) + int'(bot_cfg.scan_step);
              // high end is tested first, so crossed limits still settle
              if (next_deg >= int'(bot_cfg.scan_high)) begin
                bot.sweep_angle = bot_cfg.scan_high;
                bot.sweep_down  = 1'b1;
                bot.mode        = MODE_DECIDE;
              end else if (next_deg <= int'(bot_cfg.scan_low)) begin
                bot.sweep_angle = bot_cfg.scan_low;
                bot.sweep_down  = 1'b0;
                bot.mode        = MODE_DECIDE;
              end else begin
                bot.sweep_angle = next_deg[7:0];
              end
            end
          end
          MODE_DECIDE: begin
            bot.mode = (bot.min_cm > bot_cfg.safe_dist) ? MODE_MOVE : MODE_ALERT;
          end
          MODE_MOVE: begin
            r.motor  = MOT_FWD;
            bot.mode = MODE_SCAN;
          end
          MODE_REVERSE: begin
            r.motor = MOT_BACK;
          end
          MODE_ALERT: begin
            if (!bot.turning) begin
              // turn away from the side of the nearest obstacle
              r.motor        = (bot.min_deg < CenterDeg) ? MOT_RIGHT : MOT_LEFT;
              bot.turn_start = w.now;
              bot.turning    = 1'b1;
            end else begin
              elapsed = w.now - bot.turn_start;
              if (elapsed > 32'(bot_cfg.avoid_time)) begin
                r.motor     = MOT_STOP;
                bot.turning = 1'b0;
                bot.min_cm  = FarCm;
                bot.mode    = MODE_SCAN;
              end
            end
          end
          default: ;
        endcase
      end
    end
    r.mode        = bot.mode;
    r.auto_on     = bot.auto_on;
    r.manual_on   = bot.manual_on;
    r.nearest_cm  = bot.min_cm;
    r.nearest_deg = bot.min_deg;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: holds a word until accepted, predicts it at the accepting edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver
    in_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      // ports still carry the accepted word here, the updates below are nonblocking
      if (in_valid_i && in_ready_o) begin
        expected_outputs.push_back(robot_step('{cmd_i, rx_byte_i, now_ms_i, distance_cm_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (robot_inputs.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          w = robot_inputs.pop_front();
          cmd_i         <= w.cmd;
          rx_byte_i     <= w.rx;
          now_ms_i      <= w.now;
          distance_cm_i <= w.dist_cm;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, each taken word checked against the oldest
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_outputs.size() == 0) begin
          $error("result word with no input word outstanding");
          mismatches++;
        end else begin
          want = expected_outputs.pop_front();
          check_field("robot_mode",     32'(want.mode),        32'(robot_mode_o));
          check_field("motor_action",   32'(want.motor),       32'(motor_action_o));
          check_field("servo_write",    32'(want.servo_write), 32'(servo_write_o));
          check_field("servo_angle",    32'(want.servo_angle), 32'(servo_angle_o));
          check_field("buzzer_action",  32'(want.buzz),        32'(buzzer_action_o));
          check_field("auto_enabled",   32'(want.auto_on),     32'(auto_enabled_o));
          check_field("manual_enabled", 32'(want.manual_on),   32'(manual_enabled_o));
          check_field("nearest_cm",     32'(want.nearest_cm),  32'(nearest_cm_o));
          check_field("nearest_deg",    32'(want.nearest_deg), 32'(nearest_deg_o));
        end
      end
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_tick(input logic [31:0] t, input logic [9:0] d);
    in_word_t w;
    w.cmd     = 1'b0;
    w.rx      = 8'($urandom_range(255));   // ignored on ticks
    w.now     = t;
    w.dist_cm = d;
    robot_inputs.push_back(w);
  endfunction

  function automatic void queue_byte(input logic [7:0] ch);
    in_word_t w;
    w.cmd     = 1'b1;
    w.rx      = ch;
    w.now     = $urandom();                 // time and distance ignored on commands
    w.dist_cm = 10'($urandom_range(1023));
    robot_inputs.push_back(w);
  endfunction

  // start-auto most often so sweeps run long, the rest stop/manual/recenter/noise
  function automatic logic [7:0] random_command();
    logic [7:0]  ch;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45)      ch = "t";
    else if (pick < 57) ch = "x";
    else if (pick < 62) ch = "w";
    else if (pick < 67) ch = "s";
    else if (pick < 72) ch = "a";
    else if (pick < 77) ch = "d";
    else if (pick < 85) ch = "r";
    else                return 8'($urandom_range(255));
    if ($urandom_range(1) == 1) ch = ch ^ 8'h20;  // flip ascii case
    return ch;
  endfunction

  // readings cluster around the safe distance, with no-echo and full-range mixed in
  function automatic logic [9:0] random_distance();
    int unsigned pick;
    int unsigned near_max;
    pick     = $urandom_range(99);
    near_max = 2 * bot_cfg.safe_dist + 40;
    if (near_max > 1023) near_max = 1023;
    if (pick < 10)      return 10'd0;
    else if (pick < 30) return 10'($urandom_range(1023));
    else                return 10'($urandom_range(near_max, 1));
  endfunction

  task automatic queue_random(input int unsigned count);
    int unsigned pick;
    int unsigned tmax;
    // time steps span the scan period and reach past the avoidance time
    tmax = 2 * bot_cfg.scan_period + bot_cfg.avoid_time / 4 + 1;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 9) begin
        queue_byte(random_command());
      end else begin
        if (pick < 12) sim_now = $urandom();   // clock jump, either direction
        else           sim_now = sim_now + $urandom_range(tmax);
        queue_tick(sim_now, random_distance());
      end
    end
  endtask

  // block is idle once nothing is queued, held or expected
  task automatic wait_drained();
    do @(negedge clk_i);
    while (robot_inputs.size() != 0 || in_valid_i || expected_outputs.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SAFE_DIST:   bot_cfg.safe_dist   = val[9:0];
      REG_SCAN_PERIOD: bot_cfg.scan_period = val[9:0];
      REG_AVOID_TIME:  bot_cfg.avoid_time  = val[13:0];
      REG_SCAN_LOW:    bot_cfg.scan_low    = val[7:0];
      REG_SCAN_HIGH:   bot_cfg.scan_high   = val[7:0];
      REG_SCAN_STEP:   bot_cfg.scan_step   = val[6:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int unsigned safe, input int unsigned period,
                              input int unsigned avoid, input int unsigned low,
                              input int unsigned high, input int unsigned step);
    write_reg(REG_SAFE_DIST,   CfgDataW'(safe));
    write_reg(REG_SCAN_PERIOD, CfgDataW'(period));
    write_reg(REG_AVOID_TIME,  CfgDataW'(avoid));
    write_reg(REG_SCAN_LOW,    CfgDataW'(low));
    write_reg(REG_SCAN_HIGH,   CfgDataW'(high));
    write_reg(REG_SCAN_STEP,   CfgDataW'(step));
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned rand_low;

    // predictor starts from the reset image
    bot             = '0;
    bot.mode        = MODE_IDLE;
    bot.prior       = MODE_IDLE;
    bot.sweep_angle = ScanLowRst;   // sweep starts at the default low end
    bot.min_cm      = FarCm;
    bot.min_deg     = CenterDeg;
    bot_cfg = '{safe_dist: SafeDistRst, scan_period: ScanPeriodRst,
                avoid_time: AvoidTimeRst, scan_low: ScanLowRst,
                scan_high: ScanHighRst, scan_step: ScanStepRst};

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, on reset register values: sender idles little, receiver much
    in_idle_pct  = 22;
    out_idle_pct = 78;
    queue_tick(32'd0, 10'd0);       // auto off, tick does only the mode check
    queue_byte("s");                // manual reverse
    queue_tick(32'd1, 10'd100);     // mode changed to reverse: melody
    queue_byte("W");
    queue_byte("a");
    queue_byte("D");
    queue_byte("X");
    queue_byte(8'hFF);              // unknown byte: nothing
    queue_byte("r");                // recenter servo
    queue_byte("T");                // auto on
    // full upward sweep 30..140, clamps at the high end
    queue_tick(32'd40, 10'd0);      // no echo is not a minimum
    queue_tick(32'd60, 10'd300);    // too soon for a step
    queue_tick(32'd80, 10'd15);     // nearest, below safe, at 40 deg
    for (int unsigned k = 3; k <= 12; k++) queue_tick(32'(40 * k), 10'd500);
    queue_tick(32'd500, 10'd500);   // decide: too close, alert
    queue_tick(32'd510, 10'd500);   // alert buzzer, turn right
    queue_tick(32'd630, 10'd0);     // exactly the avoid time: keep turning
    queue_tick(32'd631, 10'd0);     // past it: stop, back to scan
    wait_drained();

    // extremes: fastest scan, shortest avoid, widest range, biggest step
    program_regs(200, 1, 1, 0, 180, 90);
    sim_now = $urandom();
    queue_random(PhaseWords);
    wait_drained();

    // slowest scan, longest avoid, finest step, always too close
    program_regs(1023, 1000, 10000, 80, 100, 1);
    sim_now = $urandom();
    queue_random(PhaseWords);
    wait_drained();

    // receiver now mostly ready, sender mostly idle
    in_idle_pct  = 78;
    out_idle_pct = 22;

    // crossed limits, never too close
    program_regs(0, 7, 30, 100, 40, 5);
    sim_now = $urandom();
    queue_random(PhaseWords);
    wait_drained();

    rand_low = $urandom_range(120);
    program_regs($urandom_range(300, 10), $urandom_range(100, 1), $urandom_range(500, 1),
                 rand_low, $urandom_range(180, rand_low), $urandom_range(45, 1));
    sim_now = $urandom();
    queue_random(PhaseWords);
    wait_drained();

    // back to back on both sides
    in_idle_pct  = 0;
    out_idle_pct = 0;

    // sweep pinned to a single angle
    program_regs($urandom_range(200), 20, 60, 90, 90, 3);
    sim_now = $urandom();
    queue_random(PhaseWords);
    wait_drained();

    // default values again, ms clock wrapping through zero
    program_regs(32'(SafeDistRst), 32'(ScanPeriodRst), 32'(AvoidTimeRst),
                 32'(ScanLowRst), 32'(ScanHighRst), 32'(ScanStepRst));
    sim_now = 32'hFFFF_FFFF - $urandom_range(2000);
    queue_random(PhaseWords);
    wait_drained();

    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
